// ===== hdl/upi_pkg.sv =====
// Package for the unicycle pose integrator: payload types, widths and CORDIC constants.
package upi_pkg;

  // Default number of CORDIC rotation stages
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ATAN_LEN          = 24;

  // Working width of the CORDIC datapath (Q2.30 vector, 2^31 = pi angle)
  localparam int unsigned CW = 32;

  // Reciprocal of the limiting CORDIC gain in Q2.30
  localparam logic signed [CW-1:0] GAIN_Q30 = 32'sd652032874;

  // Quarter turn in 16-bit binary angle units
  localparam logic signed [15:0] QUARTER_TURN = 16'sd16384;

  // atan(2^-i) in 32-bit binary angle units
  localparam logic signed [CW-1:0] ATAN_TBL [ATAN_LEN] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335086,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  // Input transaction
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [23:0] speed;
    logic signed [23:0] turn_rate;
    logic        [23:0] step_time;
  } in_t;

  // Output transaction
  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [15:0] next_heading;
  } out_t;

endpackage

// ===== hdl/upi_cordic.sv =====
// Pipelined rotation-mode CORDIC, one rotation per register stage.
module upi_cordic #(
  parameter int unsigned STAGES = upi_pkg::CORDIC_STAGES_DEF
) (
  input  logic                            clk_i,
  input  logic [STAGES-1:0]               en_i,
  input  logic signed [upi_pkg::CW-1:0]   x_i,
  input  logic signed [upi_pkg::CW-1:0]   z_i,
  output logic signed [upi_pkg::CW-1:0]   cos_o,
  output logic signed [upi_pkg::CW-1:0]   sin_o
);
  import upi_pkg::*;

  logic signed [CW-1:0] x_q [STAGES];
  logic signed [CW-1:0] y_q [STAGES];
  logic signed [CW-1:0] z_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CW-1:0] x_in, y_in, z_in;
    logic signed [CW-1:0] x_sh, y_sh;
    logic signed [CW-1:0] x_d, y_d, z_d;

    // Take the previous stage, or the start vector at the head
    if (i == 0) begin : g_head
      assign x_in = x_i;
      assign y_in = '0;
      assign z_in = z_i;
    end else begin : g_body
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    assign x_sh = x_in >>> i;
    assign y_sh = y_in >>> i;

    // Rotate toward zero residual angle
    always_comb begin
      if (!z_in[CW-1]) begin
        x_d = x_in - y_sh;
        y_d = y_in + x_sh;
        z_d = z_in - ATAN_TBL[i];
      end else begin
        x_d = x_in + y_sh;
        y_d = y_in - x_sh;
        z_d = z_in + ATAN_TBL[i];
      end
    end

    // Advance the stage when the pipeline moves
    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
      end
    end
  end

  assign cos_o = x_q[STAGES-1];
  assign sin_o = y_q[STAGES-1];

endmodule

// ===== hdl/unicycle_pose_integrator_top.sv =====
// Top level of the unicycle pose integrator: capture, CORDIC pipeline and Euler update.
//
// One Euler step of the planar unicycle model per transaction: x and y advance
// by speed * cos/sin(heading) * step_time, heading by turn_rate * step_time.
// Positions are Q16.16 and saturate; heading is a 16-bit binary angle that wraps.
// The block is a fully pipelined chain of CORDIC_STAGES + 5 register stages
// (one capture stage with quadrant folding, CORDIC_STAGES rotation stages, then
// two multiply and two rounding stages). It takes one transaction per cycle while
// the output is not stalled. Each result moves through these stages in order,
// and can be taken at the next edge. Each stage holds only while it
// is occupied and the stage after it holds, so empty slots are squeezed out
// under output stall.
module unicycle_pose_integrator_top #(
  parameter int unsigned CORDIC_STAGES = upi_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  upi_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output upi_pkg::out_t out_data_o
);
  import upi_pkg::*;

  localparam int unsigned N  = CORDIC_STAGES;
  localparam int unsigned P1 = N + 1;
  localparam int unsigned P2 = N + 2;
  localparam int unsigned P3 = N + 3;
  localparam int unsigned P4 = N + 4;
  localparam int unsigned L  = N + 5;

  // Stage control
  logic [L-1:0] valid_q, valid_d, adv;

  // Let a stage load when it is empty or its successor moves
  always_comb begin
    adv[L-1] = !valid_q[L-1] || !out_stall_i;
    for (int k = L - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign valid_d = {valid_q[L-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < L; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[L-1];

  // Capture stage: fold the angle into [-pi/2, pi/2]
  in_t                  side_q [N+1];
  logic signed [CW-1:0] z0_q, z0_d;
  logic                 neg_q, neg_d;
  logic [CW-1:0]        z_full;

  assign z_full = {in_data_i.heading, 16'b0};
  assign neg_d  = (in_data_i.heading > QUARTER_TURN) || (in_data_i.heading < -QUARTER_TURN);
  assign z0_d   = {z_full[CW-1] ^ neg_d, z_full[CW-2:0]};

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      side_q[0] <= in_data_i;
      z0_q      <= z0_d;
      neg_q     <= neg_d;
    end
  end

  // Carry the transaction alongside the CORDIC stages
  for (genvar k = 1; k <= N; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  logic signed [CW-1:0] x0, cos_w, sin_w;

  assign x0 = neg_q ? -GAIN_Q30 : GAIN_Q30;

  upi_cordic #(
    .STAGES(N)
  ) u_cordic (
    .clk_i (clk_i),
    .en_i  (adv[N:1]),
    .x_i   (x0),
    .z_i   (z0_q),
    .cos_o (cos_w),
    .sin_o (sin_w)
  );

  // First multiply: speed by trig, turn rate by step time
  logic signed [55:0] mx_q, my_q, mx_d, my_d;
  logic signed [48:0] mh_q, mh_d;
  logic signed [24:0] dt_n;
  logic signed [31:0] px1_q, py1_q;
  logic signed [15:0] hd1_q;
  logic        [23:0] st1_q;

  assign dt_n = $signed({1'b0, side_q[N].step_time});
  assign mx_d = side_q[N].speed * cos_w;
  assign my_d = side_q[N].speed * sin_w;
  assign mh_d = side_q[N].turn_rate * dt_n;

  always_ff @(posedge clk_i) begin
    if (adv[P1]) begin
      mx_q  <= mx_d;
      my_q  <= my_d;
      mh_q  <= mh_d;
      px1_q <= side_q[N].pos_x;
      py1_q <= side_q[N].pos_y;
      hd1_q <= side_q[N].heading;
      st1_q <= side_q[N].step_time;
    end
  end

  // Round products to Q16 velocity; finish the heading
  localparam logic signed [55:0] RND30 = 56'sd536870912;
  localparam logic signed [48:0] RNDH  = 49'sd32768;

  logic signed [55:0] rx_sum, ry_sum;
  logic signed [48:0] rh_sum;
  logic signed [25:0] vx_q, vy_q;
  logic signed [15:0] hd2_q, hd2_d;
  logic signed [31:0] px2_q, py2_q;
  logic        [23:0] st2_q;

  assign rx_sum = mx_q + RND30;
  assign ry_sum = my_q + RND30;
  assign rh_sum = mh_q + RNDH;
  assign hd2_d  = hd1_q + $signed(rh_sum[31:16]);

  always_ff @(posedge clk_i) begin
    if (adv[P2]) begin
      vx_q  <= rx_sum[55:30];
      vy_q  <= ry_sum[55:30];
      hd2_q <= hd2_d;
      px2_q <= px1_q;
      py2_q <= py1_q;
      st2_q <= st1_q;
    end
  end

  // Second multiply: velocity by step time
  logic signed [24:0] dt2;
  logic signed [50:0] dx_q, dy_q;
  logic signed [31:0] px3_q, py3_q;
  logic signed [15:0] hd3_q;

  assign dt2 = $signed({1'b0, st2_q});

  always_ff @(posedge clk_i) begin
    if (adv[P3]) begin
      dx_q  <= vx_q * dt2;
      dy_q  <= vy_q * dt2;
      px3_q <= px2_q;
      py3_q <= py2_q;
      hd3_q <= hd2_q;
    end
  end

  // Round the displacement, add it and saturate
  localparam logic signed [50:0] RND16 = 51'sd32768;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
      r = v[31:0];
    end else if (v[35]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  logic signed [50:0] sx_sum, sy_sum;
  logic signed [35:0] nx_sum, ny_sum;
  out_t               out_q, out_d;

  assign sx_sum = dx_q + RND16;
  assign sy_sum = dy_q + RND16;
  assign nx_sum = 36'(px3_q) + 36'($signed(sx_sum[50:16]));
  assign ny_sum = 36'(py3_q) + 36'($signed(sy_sum[50:16]));

  always_comb begin
    out_d.next_x       = sat32(nx_sum);
    out_d.next_y       = sat32(ny_sum);
    out_d.next_heading = hd3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[P4]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule
